// ===== design/skvt_pkg.sv =====
// Shared types and codes of the sorted key/value table.
`default_nettype none

package skvt_pkg;

  // Request kinds.
  localparam logic [2:0] REQ_SET       = 3'd0;
  localparam logic [2:0] REQ_DELETE    = 3'd1;
  localparam logic [2:0] REQ_GET       = 3'd2;
  localparam logic [2:0] REQ_GET_NEXT  = 3'd3;
  localparam logic [2:0] REQ_GET_FIRST = 3'd4;
  localparam logic [2:0] REQ_RM_FIRST  = 3'd5;
  localparam logic [2:0] REQ_CLEAR     = 3'd6;

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Configuration register map (index is paddr bit 2).
  localparam int unsigned CFG_ADDR_W          = 3;
  localparam logic        REG_IDX_MAX_ENTRIES = 1'b0;
  localparam logic        REG_IDX_KEY_SIGNED  = 1'b1;
  localparam logic [4:0]  MAX_ENTRIES_RESET   = 5'd16;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] req_key;
    logic [31:0] req_value;
  } skvt_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_key;
    logic [31:0] found_value;
    logic [4:0]  entries_held;
  } skvt_resp_t;

endpackage

`default_nettype wire

// ===== design/skvt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module skvt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/skvt_kcmp.sv =====
// Shared key comparator: signed or unsigned ordering of two keys.
`default_nettype none

module skvt_kcmp #(
  parameter int unsigned KEY_BITS = 32
) (
  input  wire logic [KEY_BITS-1:0] key_a,
  input  wire logic [KEY_BITS-1:0] key_b,
  input  wire logic                key_signed,
  output logic                     a_lt_b,
  output logic                     a_eq_b
);

  logic [KEY_BITS-1:0] flip;
  logic [KEY_BITS-1:0] a_biased;
  logic [KEY_BITS-1:0] b_biased;

  // Flipping the sign bit maps two's complement order onto unsigned order.
  assign flip     = {key_signed, {(KEY_BITS-1){1'b0}}};
  assign a_biased = key_a ^ flip;
  assign b_biased = key_b ^ flip;
  assign a_lt_b   = a_biased < b_biased;
  assign a_eq_b   = key_a == key_b;

endmodule

`default_nettype wire

// ===== design/sorted_key_value_table_core.sv =====
// Top level of the sorted key/value table: sequencer, count and register file.
//
//   Channel   Direction  Handshake           Payload
//   in_       input      in_valid/in_ready   skvt_req_t  (req_type, req_key, req_value)
//   out_      output     out_valid/out_ready skvt_resp_t (status, key, value, entries_held)
//   cfg_      APB        psel/penable/pready max_entries at 0x0, key_is_signed at 0x4
//
// One request at a time; in_ready is high only while the sequencer is idle.
// Lookups walk entries from the first through one shared comparator, each entry taking
// a RAM read, then a compare; insert and remove move entries one at a time, each by a
// RAM read and then a write.
// Reset clears the count but not the RAM; RAM words at or above the count are never used.
// A result not yet taken holds the sequencer in its final state until out_ready rises.
`default_nettype none

module sorted_key_value_table_core
  import skvt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned KEY_BITS    = 32,
  parameter int unsigned VALUE_BITS  = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Request channel.
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire skvt_req_t             in_req,
  // Result channel.
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output skvt_resp_t                 out_resp,
  // Configuration port.
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]           cfg_pwdata,
  output logic      [31:0]           cfg_prdata,
  output logic                       cfg_pready
);

  localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_DECIDE,
    S_FET_RD,
    S_FET_CAP,
    S_UP_RD,
    S_UP_WR,
    S_DN_RD,
    S_DN_WR,
    S_DONE
  } state_t;

  state_t                state_r,        state_nxt;
  logic [2:0]            req_type_r,     req_type_nxt;
  logic [KEY_BITS-1:0]   req_key_r,      req_key_nxt;
  logic [VALUE_BITS-1:0] req_val_r,      req_val_nxt;
  logic [CNT_W-1:0]      count_r,        count_nxt;
  logic [CNT_W-1:0]      idx_r,          idx_nxt;
  logic [CNT_W-1:0]      pos_r,          pos_nxt;
  logic                  hit_r,          hit_nxt;
  logic [1:0]            res_status_r,   res_status_nxt;
  logic [KEY_BITS-1:0]   res_key_r,      res_key_nxt;
  logic [VALUE_BITS-1:0] res_val_r,      res_val_nxt;
  logic                  out_valid_r,    out_valid_nxt;
  skvt_resp_t            out_resp_r,     out_resp_nxt;
  logic [4:0]            max_entries_r,  max_entries_nxt;
  logic                  key_signed_r,   key_signed_nxt;

  // RAM port controls, shared by the key and value arrays.
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [KEY_BITS-1:0]   key_wdata;
  logic [VALUE_BITS-1:0] val_wdata;
  logic [KEY_BITS-1:0]   key_rd;
  logic [VALUE_BITS-1:0] val_rd;

  logic                  cmp_lt;
  logic                  cmp_eq;

  logic [CNT_W-1:0]      idx_inc;
  logic [CNT_W-1:0]      idx_dec;
  logic [CNT_W-1:0]      pos_inc;
  logic                  table_full;
  logic [31:0]           limit_ext;
  logic [63:0]           in_key_ext;
  logic [63:0]           in_val_ext;
  logic [63:0]           res_key_ext;
  logic [63:0]           res_val_ext;
  logic [31:0]           count_ext;
  logic                  cfg_wr;

  skvt_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (key_wdata),
    .raddr (ram_raddr),
    .rdata (key_rd)
  );

  skvt_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_val_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (val_wdata),
    .raddr (ram_raddr),
    .rdata (val_rd)
  );

  // The one comparator: stored key read from the RAM against the request key.
  skvt_kcmp #(
    .KEY_BITS (KEY_BITS)
  ) u_kcmp (
    .key_a      (key_rd),
    .key_b      (req_key_r),
    .key_signed (key_signed_r),
    .a_lt_b     (cmp_lt),
    .a_eq_b     (cmp_eq)
  );

  assign idx_inc = idx_r + CNT_W'(1);
  assign idx_dec = idx_r - CNT_W'(1);
  assign pos_inc = pos_r + CNT_W'(1);

  // Capacity is the smaller of the register and the physical depth.
  assign limit_ext  = (32'(max_entries_r) < 32'(TABLE_DEPTH)) ? 32'(max_entries_r)
                                                             : 32'(TABLE_DEPTH);
  assign table_full = 32'(count_r) >= limit_ext;

  // Request fields are cut or zero-extended to the stored widths, results back.
  assign in_key_ext  = 64'(in_req.req_key);
  assign in_val_ext  = 64'(in_req.req_value);
  assign res_key_ext = 64'(res_key_r);
  assign res_val_ext = 64'(res_val_r);
  assign count_ext   = 32'(count_r);

  // Configuration access; pready is tied high so every access ends at once.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_IDX_KEY_SIGNED) ? {31'd0, key_signed_r}
                                                           : {27'd0, max_entries_r};

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_resp  = out_resp_r;

  always_comb begin
    state_nxt       = state_r;
    req_type_nxt    = req_type_r;
    req_key_nxt     = req_key_r;
    req_val_nxt     = req_val_r;
    count_nxt       = count_r;
    idx_nxt         = idx_r;
    pos_nxt         = pos_r;
    hit_nxt         = hit_r;
    res_status_nxt  = res_status_r;
    res_key_nxt     = res_key_r;
    res_val_nxt     = res_val_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_resp_nxt    = out_resp_r;
    max_entries_nxt = max_entries_r;
    key_signed_nxt  = key_signed_r;

    ram_we    = 1'b0;
    ram_waddr = idx_r[ADDR_W-1:0];
    ram_raddr = idx_r[ADDR_W-1:0];
    key_wdata = key_rd;
    val_wdata = val_rd;

    if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_IDX_MAX_ENTRIES: max_entries_nxt = cfg_pwdata[4:0];
        REG_IDX_KEY_SIGNED:  key_signed_nxt  = cfg_pwdata[0];
        default:             max_entries_nxt = max_entries_r;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_type_nxt   = in_req.req_type;
          req_key_nxt    = in_key_ext[KEY_BITS-1:0];
          req_val_nxt    = in_val_ext[VALUE_BITS-1:0];
          res_status_nxt = ST_OK;
          res_key_nxt    = '0;
          res_val_nxt    = '0;
          idx_nxt        = '0;
          pos_nxt        = '0;
          hit_nxt        = 1'b0;
          case (in_req.req_type) inside
            REQ_SET, REQ_DELETE, REQ_GET, REQ_GET_NEXT: begin
              // An empty table needs no walk: the insert point is the front.
              state_nxt = (count_r == '0) ? S_DECIDE : S_SRCH_RD;
            end
            REQ_GET_FIRST, REQ_RM_FIRST: begin
              if (count_r == '0) begin
                res_status_nxt = ST_NONE;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_FET_RD;
              end
            end
            REQ_CLEAR: begin
              count_nxt = '0;
              state_nxt = S_DONE;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_SRCH_RD: begin
        state_nxt = S_SRCH_CMP;
      end

      S_SRCH_CMP: begin
        // The first entry not below the request key ends the walk; its key and
        // value are kept since most request kinds return that entry.
        if (!cmp_lt) begin
          pos_nxt     = idx_r;
          hit_nxt     = cmp_eq;
          res_key_nxt = key_rd;
          res_val_nxt = val_rd;
          state_nxt   = S_DECIDE;
        end else if (idx_inc == count_r) begin
          pos_nxt   = count_r;
          hit_nxt   = 1'b0;
          state_nxt = S_DECIDE;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_SRCH_RD;
        end
      end

      S_DECIDE: begin
        state_nxt = S_DONE;
        case (req_type_r)
          REQ_SET: begin
            if (hit_r) begin
              ram_we      = 1'b1;
              ram_waddr   = pos_r[ADDR_W-1:0];
              key_wdata   = req_key_r;
              val_wdata   = req_val_r;
              res_key_nxt = req_key_r;
              res_val_nxt = req_val_r;
            end else if (table_full) begin
              res_status_nxt = ST_FULL;
              res_key_nxt    = '0;
              res_val_nxt    = '0;
            end else begin
              // Open a gap at the insert point, moving entries from the back.
              idx_nxt   = count_r;
              state_nxt = S_UP_RD;
            end
          end
          REQ_DELETE: begin
            if (hit_r) begin
              idx_nxt   = pos_r;
              state_nxt = S_DN_RD;
            end else begin
              res_status_nxt = ST_NONE;
              res_key_nxt    = '0;
              res_val_nxt    = '0;
            end
          end
          REQ_GET: begin
            if (!hit_r) begin
              res_status_nxt = ST_NONE;
              res_key_nxt    = '0;
              res_val_nxt    = '0;
            end
          end
          REQ_GET_NEXT: begin
            if (hit_r) begin
              // Equal key: the answer is the entry after the match.
              if (pos_inc < count_r) begin
                idx_nxt   = pos_inc;
                state_nxt = S_FET_RD;
              end else begin
                res_status_nxt = ST_NONE;
                res_key_nxt    = '0;
                res_val_nxt    = '0;
              end
            end else if (pos_r >= count_r) begin
              res_status_nxt = ST_NONE;
              res_key_nxt    = '0;
              res_val_nxt    = '0;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      S_FET_RD: begin
        state_nxt = S_FET_CAP;
      end

      S_FET_CAP: begin
        res_key_nxt = key_rd;
        res_val_nxt = val_rd;
        state_nxt   = (req_type_r == REQ_RM_FIRST) ? S_DN_RD : S_DONE;
      end

      S_UP_RD: begin
        if (idx_r > pos_r) begin
          ram_raddr = idx_dec[ADDR_W-1:0];
          state_nxt = S_UP_WR;
        end else begin
          ram_we      = 1'b1;
          ram_waddr   = pos_r[ADDR_W-1:0];
          key_wdata   = req_key_r;
          val_wdata   = req_val_r;
          count_nxt   = count_r + CNT_W'(1);
          res_key_nxt = req_key_r;
          res_val_nxt = req_val_r;
          state_nxt   = S_DONE;
        end
      end

      S_UP_WR: begin
        ram_we    = 1'b1;
        idx_nxt   = idx_dec;
        state_nxt = S_UP_RD;
      end

      S_DN_RD: begin
        if (idx_inc < count_r) begin
          ram_raddr = idx_inc[ADDR_W-1:0];
          state_nxt = S_DN_WR;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_DONE;
        end
      end

      S_DN_WR: begin
        ram_we    = 1'b1;
        idx_nxt   = idx_inc;
        state_nxt = S_DN_RD;
      end

      S_DONE: begin
        // The result moves to the output register once that register is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt             = 1'b1;
          out_resp_nxt.status       = res_status_r;
          out_resp_nxt.found_key    = res_key_ext[31:0];
          out_resp_nxt.found_value  = res_val_ext[31:0];
          out_resp_nxt.entries_held = count_ext[4:0];
          state_nxt                 = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      count_r       <= '0;
      out_valid_r   <= 1'b0;
      max_entries_r <= MAX_ENTRIES_RESET;
      key_signed_r  <= 1'b1;
    end else begin
      state_r       <= state_nxt;
      count_r       <= count_nxt;
      out_valid_r   <= out_valid_nxt;
      max_entries_r <= max_entries_nxt;
      key_signed_r  <= key_signed_nxt;
    end
    req_type_r   <= req_type_nxt;
    req_key_r    <= req_key_nxt;
    req_val_r    <= req_val_nxt;
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    hit_r        <= hit_nxt;
    res_status_r <= res_status_nxt;
    res_key_r    <= res_key_nxt;
    res_val_r    <= res_val_nxt;
    out_resp_r   <= out_resp_nxt;
  end

endmodule

`default_nettype wire
